>>> src/asws_pkg.sv
// ----------------------------------------------------------------------------
// asws_pkg
// Shared constants and types for the ADC scan window statistics unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asws_pkg;

    // ring geometry
    localparam int RING_DEPTH = 32;
    localparam int CHANNELS   = 2;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int WINDOW_W   = 16;
    localparam int DISCARD_W  = 4;
    localparam int ACTIVE_W   = 2;
    localparam int MODE_W     = 2;
    localparam int USED_W     = 6;
    localparam int CH_W       = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int POS_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int MEM_DEPTH  = CHANNELS * RING_DEPTH;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int WORD_W     = TIME_W + SAMPLE_W;
    localparam int SUM_W      = SAMPLE_W + CNT_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // register reset values
    localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = WINDOW_W'(1200);
    localparam logic [DISCARD_W-1:0] DISCARD_RESET = DISCARD_W'(3);
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = ACTIVE_W'(2);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = CFG_IDX_W'(2);

    // transaction modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_FAULT  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_QUERY  = MODE_W'(2);

    // status codes
    typedef enum logic [1:0] {
        STAT_WAITING = 2'd0,
        STAT_OK      = 2'd1,
        STAT_TIMEOUT = 2'd2,
        STAT_ERROR   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV
    } t_state;

endpackage

>>> src/adc_scan_window_statistics_unit.sv
// ----------------------------------------------------------------------------
// adc_scan_window_statistics_unit
// Round-robin ADC sample capture into per-channel rings with windowed
// minimum, maximum and truncated average on query.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start, busy          | i_mode, i_sample_value, i_time_ms,
//            |                      | i_fault_is_timeout, i_query_channel
//  result    | o_valid (1 cycle)    | o_stored .. o_scanning
//  config    | i_cfg_we             | i_cfg_index, i_cfg_wdata
//
//  sample, fault and unused-mode transactions: result in the cycle after accept,
//  busy stays low.
//  query: ring walk through the single ring read port, then a restoring divider
//  when any sample lies in the window.
//  a query of a channel with no stored sample answers in the cycle after accept.
//  reset is synchronous; rings need no clearing pass, the fill count bounds reads.
//  results cannot be stalled: o_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_scan_window_statistics_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [asws_pkg::MODE_W-1:0]     i_mode,
    input  logic signed [asws_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [asws_pkg::TIME_W-1:0]     i_time_ms,
    input  logic                            i_fault_is_timeout,
    input  logic [asws_pkg::CH_W-1:0]       i_query_channel,
    input  logic                            i_cfg_we,
    input  logic [asws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [asws_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                            o_valid,
    output logic                            o_stored,
    output logic [asws_pkg::CH_W-1:0]       o_stored_channel,
    output logic signed [asws_pkg::SAMPLE_W-1:0] o_average,
    output logic signed [asws_pkg::SAMPLE_W-1:0] o_minimum,
    output logic signed [asws_pkg::SAMPLE_W-1:0] o_maximum,
    output logic [asws_pkg::USED_W-1:0]     o_used_count,
    output logic signed [asws_pkg::SAMPLE_W-1:0] o_latest_value,
    output logic [1:0]                      o_status,
    output logic                            o_scanning
);
    import asws_pkg::*;

    // configuration
    logic [WINDOW_W-1:0]  r_window;
    logic [DISCARD_W-1:0] r_discard;
    logic [ACTIVE_W-1:0]  r_active;

    // per-channel bookkeeping
    logic [CNT_W-1:0]           r_fill   [CHANNELS];
    logic [POS_W-1:0]           r_wpos   [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_newest [CHANNELS];
    logic                       r_has    [CHANNELS];

    // scan state
    logic [CH_W-1:0]      r_cur_ch;
    logic [DISCARD_W-1:0] r_settle;
    logic                 r_scan_on;
    t_status              r_status;

    // sequencer
    t_state r_state;
    t_state n_state;

    // ring memory: time in the upper part, sample in the lower
    logic [WORD_W-1:0] r_mem [MEM_DEPTH];
    logic [WORD_W-1:0] r_rd_word;

    // query context
    logic [CH_W-1:0]            r_qch;
    logic [CNT_W-1:0]           r_n;
    logic signed [SAMPLE_W-1:0] r_q_newest;
    logic [TIME_W-1:0]          r_now;
    logic [CNT_W-1:0]           r_rd_idx;
    logic                       r_v1;
    logic                       r_hit;
    logic signed [SAMPLE_W-1:0] r_hit_sample;

    // accumulators
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic [CNT_W-1:0]           r_used;

    // divider
    logic [SUM_W-1:0]     r_quot;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_neg;

    // result registers
    logic                       r_valid;
    logic                       r_stored;
    logic [CH_W-1:0]            r_stored_ch;
    logic signed [SAMPLE_W-1:0] r_avg;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [USED_W-1:0]          r_used_out;
    logic signed [SAMPLE_W-1:0] r_latest;

    // control
    logic accept;
    logic rd_en;
    logic scan_end;
    logic div_end;

    // datapath nets
    logic [CH_W-1:0]            sel_ch;
    logic [CNT_W-1:0]           sel_fill;
    logic [POS_W-1:0]           sel_wpos;
    logic signed [SAMPLE_W-1:0] sel_newest;
    logic                       sel_has;
    logic                       do_store;
    logic [ACTIVE_W-1:0]        ch_total;
    logic [ACTIVE_W-1:0]        ch_inc;
    logic [CH_W-1:0]            next_ch;
    logic [MEM_AW-1:0]          wr_addr;
    logic [MEM_AW-1:0]          rd_addr;
    logic [TIME_W-1:0]          age;
    logic                       hit;
    logic signed [SUM_W-1:0]    hit_ext;
    logic [SUM_W-1:0]           sum_mag;
    logic [CNT_W:0]             rem_sh;
    logic                       qbit;
    logic [SUM_W-1:0]           quot_signed;

    function automatic logic [MEM_AW-1:0] ring_addr(input logic [CH_W-1:0] ch,
                                                     input logic [POS_W-1:0] pos);
        ring_addr = MEM_AW'(ch) * MEM_AW'(RING_DEPTH) + MEM_AW'(pos);
    endfunction

    // channel selection for the incoming transaction
    assign sel_ch     = (i_mode == MODE_QUERY) ? i_query_channel : r_cur_ch;
    assign sel_fill   = r_fill[sel_ch];
    assign sel_wpos   = r_wpos[sel_ch];
    assign sel_newest = r_newest[sel_ch];
    assign sel_has    = r_has[sel_ch];

    assign do_store = accept && (i_mode == MODE_SAMPLE) && r_scan_on &&
                      (r_settle == '0);

    // round robin channel count, clamped to the implemented channels
    always_comb begin
        priority if (r_active == '0) begin
            ch_total = ACTIVE_W'(1);
        end else if (r_active > ACTIVE_W'(CHANNELS)) begin
            ch_total = ACTIVE_W'(CHANNELS);
        end else begin
            ch_total = r_active;
        end
    end

    assign ch_inc  = ACTIVE_W'(r_cur_ch) + ACTIVE_W'(1);
    assign next_ch = (ch_inc >= ch_total) ? '0 : ch_inc[CH_W-1:0];

    assign wr_addr = ring_addr(r_cur_ch, sel_wpos);
    assign rd_addr = ring_addr(r_qch, r_rd_idx[POS_W-1:0]);

    // window test on the word read last cycle
    assign age     = r_now - r_rd_word[WORD_W-1:SAMPLE_W];
    assign hit     = r_v1 && (age <= TIME_W'(r_window));
    assign hit_ext = SUM_W'(r_hit_sample);
    assign sum_mag = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

    // one restoring division step
    assign rem_sh      = {r_rem, r_quot[SUM_W-1]};
    assign qbit        = (rem_sh >= {1'b0, r_used});
    assign quot_signed = r_neg ? (~r_quot + SUM_W'(1)) : r_quot;

    // sequencer next state and controls
    always_comb begin
        n_state  = r_state;
        accept   = 1'b0;
        rd_en    = 1'b0;
        scan_end = 1'b0;
        div_end  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                accept = start;
                if (start && (i_mode == MODE_QUERY) && sel_has) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en = (r_rd_idx < r_n);
                if (!rd_en && !r_v1 && !r_hit) begin
                    scan_end = 1'b1;
                    n_state  = (r_used != '0) ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(SUM_W)) begin
                    div_end = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring write and registered read
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[wr_addr] <= {i_time_ms, i_sample_value};
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    // window pipeline stage
    always_ff @(posedge i_clk) begin
        r_hit_sample <= r_rd_word[SAMPLE_W-1:0];
    end

    // control, bookkeeping and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_discard <= DISCARD_RESET;
            r_active  <= ACTIVE_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c]   <= '0;
                r_wpos[c]   <= '0;
                r_newest[c] <= '0;
                r_has[c]    <= 1'b0;
            end
            r_cur_ch  <= '0;
            r_settle  <= DISCARD_RESET;
            r_scan_on <= 1'b1;
            r_status  <= STAT_WAITING;
            r_valid   <= 1'b0;
            r_v1      <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_v1    <= rd_en;
            r_hit   <= hit;

            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW:  r_window  <= i_cfg_wdata[WINDOW_W-1:0];
                    CFG_DISCARD: r_discard <= i_cfg_wdata[DISCARD_W-1:0];
                    CFG_ACTIVE:  r_active  <= i_cfg_wdata[ACTIVE_W-1:0];
                    default: ;
                endcase
            end

            // new transaction
            if (accept) begin
                r_valid     <= !((i_mode == MODE_QUERY) && sel_has);
                r_stored    <= 1'b0;
                r_stored_ch <= '0;
                r_avg       <= '0;
                r_min       <= '0;
                r_max       <= '0;
                r_used_out  <= '0;
                r_latest    <= '0;
                priority if ((i_mode == MODE_SAMPLE) && r_scan_on) begin
                    r_status <= STAT_OK;
                    if (r_settle != '0) begin
                        r_settle <= r_settle - DISCARD_W'(1);
                    end else begin
                        r_newest[r_cur_ch] <= i_sample_value;
                        r_has[r_cur_ch]    <= 1'b1;
                        r_wpos[r_cur_ch]   <= (sel_wpos == POS_W'(RING_DEPTH - 1)) ?
                                              '0 : sel_wpos + POS_W'(1);
                        if (sel_fill < CNT_W'(RING_DEPTH)) begin
                            r_fill[r_cur_ch] <= sel_fill + CNT_W'(1);
                        end
                        r_stored    <= 1'b1;
                        r_stored_ch <= r_cur_ch;
                        r_cur_ch    <= next_ch;
                        r_settle    <= r_discard;
                    end
                end else if ((i_mode == MODE_FAULT) && r_scan_on) begin
                    r_status  <= i_fault_is_timeout ? STAT_TIMEOUT : STAT_ERROR;
                    r_scan_on <= 1'b0;
                end else if (i_mode == MODE_QUERY) begin
                    r_qch      <= i_query_channel;
                    r_n        <= sel_fill;
                    r_q_newest <= sel_newest;
                    r_now      <= i_time_ms;
                    r_rd_idx   <= '0;
                    r_sum      <= '0;
                    r_used     <= '0;
                end else begin
                    // scanning stopped or unused mode: status only
                end
            end

            // ring walk
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (r_hit) begin
                if ((r_used == '0) || (r_hit_sample < r_lo)) begin
                    r_lo <= r_hit_sample;
                end
                if ((r_used == '0) || (r_hit_sample > r_hi)) begin
                    r_hi <= r_hit_sample;
                end
                r_sum  <= r_sum + hit_ext;
                r_used <= r_used + CNT_W'(1);
            end

            // end of walk: newest sample fallback or divider start
            if (scan_end) begin
                if (r_used == '0) begin
                    r_valid    <= 1'b1;
                    r_avg      <= r_q_newest;
                    r_min      <= r_q_newest;
                    r_max      <= r_q_newest;
                    r_used_out <= USED_W'(1);
                    r_latest   <= r_q_newest;
                end else begin
                    r_quot    <= sum_mag;
                    r_neg     <= r_sum[SUM_W-1];
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                end
            end

            // divider iterations
            if ((r_state == ST_DIV) && !div_end) begin
                r_rem     <= qbit ? CNT_W'(rem_sh - {1'b0, r_used}) : rem_sh[CNT_W-1:0];
                r_quot    <= {r_quot[SUM_W-2:0], qbit};
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            if (div_end) begin
                r_valid    <= 1'b1;
                r_avg      <= quot_signed[SAMPLE_W-1:0];
                r_min      <= r_lo;
                r_max      <= r_hi;
                r_used_out <= USED_W'(r_used);
                r_latest   <= r_q_newest;
            end
        end
    end

    // outputs
    assign busy             = (r_state != ST_IDLE);
    assign o_valid          = r_valid;
    assign o_stored         = r_stored;
    assign o_stored_channel = r_stored_ch;
    assign o_average        = r_avg;
    assign o_minimum        = r_min;
    assign o_maximum        = r_max;
    assign o_used_count     = r_used_out;
    assign o_latest_value   = r_latest;
    assign o_status         = r_status;
    assign o_scanning       = r_scan_on;

endmodule

>>> src/asws_chk.sv
// ----------------------------------------------------------------------------
// asws_chk
// Port-level checks for the ADC scan window statistics unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asws_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [asws_pkg::MODE_W-1:0]     i_mode,
    input logic                            o_valid,
    input logic                            o_stored,
    input logic [asws_pkg::CH_W-1:0]       o_stored_channel,
    input logic signed [asws_pkg::SAMPLE_W-1:0] o_average,
    input logic signed [asws_pkg::SAMPLE_W-1:0] o_minimum,
    input logic signed [asws_pkg::SAMPLE_W-1:0] o_maximum,
    input logic [asws_pkg::USED_W-1:0]     o_used_count,
    input logic signed [asws_pkg::SAMPLE_W-1:0] o_latest_value,
    input logic                            o_scanning
);
    import asws_pkg::*;

    // non-query transactions answer in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode != MODE_QUERY)) |=> o_valid)
        else $error("missing result after non-query transaction");

    // no result while a query is in progress
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobe while busy");

    // once stopped, scanning stays stopped until reset
    a_scan_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_scanning |=> !o_scanning)
        else $error("scanning restarted without reset");

    // a stored sample never carries statistics
    a_store_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stored) |-> (o_used_count == '0))
        else $error("statistics on a store result");

    // no samples used means all statistics are zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_used_count == '0)) |->
        ((o_average == '0) && (o_minimum == '0) && (o_maximum == '0) &&
         (o_latest_value == '0) && (o_stored || (o_stored_channel == '0))))
        else $error("nonzero statistics with zero count");

endmodule

bind adc_scan_window_statistics_unit asws_chk u_asws_chk (.*);

>>> tb/adc_scan_window_statistics_unit_test.sv
// ----------------------------------------------------------------------------
// adc_scan_window_statistics_unit_test
// Self-checking bench for the ADC scan window statistics unit. Directed tests
// cover empty channels, settling drops, window edges across the time wrap,
// truncated averages at the sample extremes and the fault stop. A random
// traffic phase runs conversions and queries under several register settings.
// Every transaction is mirrored in a bench-side model of the rings, and each
// result is compared field by field against the oldest predicted report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_scan_window_statistics_unit_test;

    import asws_pkg::*;

    // codes the package leaves unnamed
    localparam logic [MODE_W-1:0]    MODE_UNUSED = MODE_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = CFG_IDX_W'(3);

    localparam logic [TIME_W-1:0]   T_BASE        = 32'hFFFF_FF00;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN    = 24'h800000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 24'h7FFFFF;
    localparam int                  PHASES        = 8;
    localparam int                  PHASE_ITEMS   = 250;
    localparam int                  SETTLE_CYCLES = 80;
    localparam longint              RUN_LIMIT_NS  = 15_000_000;

    // one result of the unit
    typedef struct packed {
        logic                       stored;
        logic [CH_W-1:0]            stored_ch;
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic [USED_W-1:0]          used;
        logic signed [SAMPLE_W-1:0] latest;
        t_status                    status;
        logic                       scanning;
    } t_scan_report;

    // dut ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [MODE_W-1:0]           i_mode = MODE_SAMPLE;
    logic signed [SAMPLE_W-1:0]  i_sample_value = '0;
    logic [TIME_W-1:0]           i_time_ms = '0;
    logic                        i_fault_is_timeout = 1'b0;
    logic [CH_W-1:0]             i_query_channel = '0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = CFG_WINDOW;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata = '0;
    logic                        o_valid;
    logic                        o_stored;
    logic [CH_W-1:0]             o_stored_channel;
    logic signed [SAMPLE_W-1:0]  o_average;
    logic signed [SAMPLE_W-1:0]  o_minimum;
    logic signed [SAMPLE_W-1:0]  o_maximum;
    logic [USED_W-1:0]           o_used_count;
    logic signed [SAMPLE_W-1:0]  o_latest_value;
    logic [1:0]                  o_status;
    logic                        o_scanning;

    // bench-side copy of registers and ring state
    logic [WINDOW_W-1:0]         cfg_window;
    logic [DISCARD_W-1:0]        cfg_discard;
    logic [ACTIVE_W-1:0]         cfg_active;
    logic signed [SAMPLE_W-1:0]  ring_value [CHANNELS][RING_DEPTH];
    logic [TIME_W-1:0]           ring_stamp [CHANNELS][RING_DEPTH];
    int                          ring_fill [CHANNELS];
    int                          ring_wpos [CHANNELS];
    logic signed [SAMPLE_W-1:0]  last_value [CHANNELS];
    logic                        last_valid [CHANNELS];
    int                          scan_ch;
    int                          settle_cnt;
    logic                        scan_live;
    t_status                     stat_now;

    t_scan_report                pending_reports [$];
    t_scan_report                report_head;
    int                          mismatch_count = 0;
    logic [TIME_W-1:0]           now_ms;

    adc_scan_window_statistics_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_sample_value     (i_sample_value),
        .i_time_ms          (i_time_ms),
        .i_fault_is_timeout (i_fault_is_timeout),
        .i_query_channel    (i_query_channel),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_stored           (o_stored),
        .o_stored_channel   (o_stored_channel),
        .o_average          (o_average),
        .o_minimum          (o_minimum),
        .o_maximum          (o_maximum),
        .o_used_count       (o_used_count),
        .o_latest_value     (o_latest_value),
        .o_status           (o_status),
        .o_scanning         (o_scanning)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // state after reset
    task automatic reset_predictor();
        cfg_window   = WINDOW_RESET;
        cfg_discard  = DISCARD_RESET;
        cfg_active   = ACTIVE_RESET;
        for (int c = 0; c < CHANNELS; c++) begin
            ring_fill[c]  = 0;
            ring_wpos[c]  = 0;
            last_value[c] = '0;
            last_valid[c] = 1'b0;
        end
        scan_ch      = 0;
        settle_cnt   = int'(DISCARD_RESET);
        scan_live    = 1'b1;
        stat_now     = STAT_WAITING;
    endtask

    // advance the model by one transaction and return its report
    function automatic t_scan_report compute_report(
        logic [MODE_W-1:0] mode, logic signed [SAMPLE_W-1:0] value,
        logic [TIME_W-1:0] now, logic timeout, logic [CH_W-1:0] qch);
        t_scan_report               r;
        longint                     sum;
        int                         used;
        int                         ch;
        int                         total;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] s;
        logic [TIME_W-1:0]          age;
        r    = '0;
        sum  = 0;
        used = 0;
        lo   = '0;
        hi   = '0;
        if (mode == MODE_SAMPLE && scan_live) begin
            stat_now = STAT_OK;
            if (settle_cnt > 0) begin
                settle_cnt--;
            end else begin
                ch = scan_ch;
                ring_value[ch][ring_wpos[ch]] = value;
                ring_stamp[ch][ring_wpos[ch]] = now;
                last_value[ch] = value;
                last_valid[ch] = 1'b1;
                ring_wpos[ch]  = (ring_wpos[ch] + 1) % RING_DEPTH;
                if (ring_fill[ch] < RING_DEPTH) ring_fill[ch]++;
                r.stored    = 1'b1;
                r.stored_ch = CH_W'(ch);
                // zero acts as one channel, anything above the channel count clamps
                total = (cfg_active == 0) ? 1 :
                        (int'(cfg_active) > CHANNELS) ? CHANNELS : int'(cfg_active);
                scan_ch    = (ch + 1) % total;
                settle_cnt = int'(cfg_discard);
            end
        end else if (mode == MODE_FAULT && scan_live) begin
            stat_now  = timeout ? STAT_TIMEOUT : STAT_ERROR;
            scan_live = 1'b0;
        end else if (mode == MODE_QUERY && last_valid[qch]) begin
            // walk the filled part of the ring, wrapping age
            for (int i = 0; i < ring_fill[qch]; i++) begin
                age = now - ring_stamp[qch][i];
                if (age <= TIME_W'(cfg_window)) begin
                    s = ring_value[qch][i];
                    if (used == 0 || s < lo) lo = s;
                    if (used == 0 || s > hi) hi = s;
                    sum += s;
                    used++;
                end
            end
            if (used == 0) begin
                // nothing in the window: fall back to the newest sample
                r.average = last_value[qch];
                r.minimum = last_value[qch];
                r.maximum = last_value[qch];
                r.used    = USED_W'(1);
            end else begin
                r.average = SAMPLE_W'(sum / used);
                r.minimum = lo;
                r.maximum = hi;
                r.used    = USED_W'(used);
            end
            r.latest = last_value[qch];
        end
        r.status   = stat_now;
        r.scanning = scan_live;
        return r;
    endfunction

    // one transaction on the command port
    task automatic send_transaction(logic [MODE_W-1:0] mode,
        logic signed [SAMPLE_W-1:0] value, logic [TIME_W-1:0] t,
        logic timeout, logic [CH_W-1:0] qch);
        @(negedge i_clk);
        i_mode             = mode;
        i_sample_value     = value;
        i_time_ms          = t;
        i_fault_is_timeout = timeout;
        i_query_channel    = qch;
        start              = 1'b1;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
        pending_reports.push_back(compute_report(mode, value, t, timeout, qch));
    endtask

    // sender gap with start held low
    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every predicted report has arrived
    task automatic wait_all_reports();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only while the unit is idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx,
        logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(posedge i_clk);
        case (idx)
            CFG_WINDOW:  cfg_window  = data[WINDOW_W-1:0];
            CFG_DISCARD: cfg_discard = data[DISCARD_W-1:0];
            CFG_ACTIVE:  cfg_active  = data[ACTIVE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // sample values biased toward the extremes
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // field compare with report
    task automatic check_field(string name, logic signed [31:0] expv,
        logic signed [31:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result with no transaction outstanding, actual status %0d",
                         $time, o_status);
                mismatch_count++;
            end else begin
                report_head = pending_reports.pop_front();
                check_field("stored", report_head.stored, o_stored);
                check_field("stored_channel", report_head.stored_ch, o_stored_channel);
                check_field("average", report_head.average, o_average);
                check_field("minimum", report_head.minimum, o_minimum);
                check_field("maximum", report_head.maximum, o_maximum);
                check_field("used_count", report_head.used, o_used_count);
                check_field("latest_value", report_head.latest, o_latest_value);
                check_field("status", report_head.status, o_status);
                check_field("scanning", report_head.scanning, o_scanning);
            end
        end
    end

    // queries before anything is stored, plus the unused mode
    task automatic test_empty_query();
        send_transaction(MODE_QUERY, random_sample(), $urandom(), 1'b1, 1'b0);
        send_transaction(MODE_QUERY, random_sample(), $urandom(), 1'b0, 1'b1);
        send_transaction(MODE_UNUSED, random_sample(), $urandom(), 1'b1, 1'b1);
    endtask

    // settling drops after each switch, extreme values, store across the time wrap
    task automatic test_settling();
        repeat (3) send_transaction(MODE_SAMPLE, random_sample(), T_BASE, 1'b0, 1'b0);
        send_transaction(MODE_SAMPLE, SAMPLE_MIN, T_BASE, 1'b0, 1'b0);
        // new discard count only applies from the next switch on
        wait_all_reports();
        write_register(CFG_DISCARD, 16'h0000);
        repeat (3) send_transaction(MODE_SAMPLE, random_sample(), T_BASE + 32'h150, 1'b1, 1'b1);
        send_transaction(MODE_SAMPLE, SAMPLE_MAX, T_BASE + 32'h150, 1'b1, 1'b1);
    endtask

    // age exactly at the window, one past it, and a sample from the future
    task automatic test_window_edges();
        send_transaction(MODE_QUERY, random_sample(), T_BASE + 32'd1200, 1'b0, 1'b0);
        send_transaction(MODE_QUERY, random_sample(), T_BASE + 32'd1201, 1'b0, 1'b0);
        send_transaction(MODE_QUERY, random_sample(), T_BASE + 32'h14F, 1'b0, 1'b1);
    endtask

    // average of negative extremes truncates toward zero, windows 0 and max
    task automatic test_truncation();
        wait_all_reports();
        write_register(CFG_WINDOW, 16'h0000);
        write_register(CFG_ACTIVE, 16'hABC1);
        send_transaction(MODE_SAMPLE, SAMPLE_MIN, T_BASE + 32'd2000, 1'b0, 1'b0);
        send_transaction(MODE_SAMPLE, SAMPLE_MIN + 24'd1, T_BASE + 32'd2000, 1'b0, 1'b0);
        send_transaction(MODE_QUERY, random_sample(), T_BASE + 32'd2000, 1'b0, 1'b0);
        wait_all_reports();
        write_register(CFG_WINDOW, 16'hFFFF);
        send_transaction(MODE_QUERY, random_sample(), T_BASE + 32'd2000, 1'b1, 1'b0);
        wait_all_reports();
        write_register(CFG_ACTIVE, 16'h0003);
    endtask

    // mixed conversions and queries under a series of register settings
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] win;
        logic [MODE_W-1:0]     mode;
        logic [TIME_W-1:0]     t;
        int                    step_max;
        int                    pick;
        bit                    idle_on;
        now_ms = T_BASE + 32'd3000;
        for (int p = 0; p < PHASES; p++) begin
            wait_all_reports();
            case ($urandom_range(0, 4))
                0:       win = 16'd1;
                1:       win = 16'($urandom_range(2, 400));
                2:       win = WINDOW_RESET;
                default: win = 16'($urandom());
            endcase
            if (p == 0) win = 16'h0000;
            if (p == 1) win = 16'hFFFF;
            write_register(CFG_WINDOW, win);
            write_register(CFG_DISCARD, (p == 0) ? 16'h000F : (p == 1) ? 16'h0000 :
                           {12'($urandom()), 4'($urandom_range(0, 4))});
            write_register(CFG_ACTIVE, {14'($urandom()), 2'(p % 4)});
            if (p == 2) write_register(CFG_UNUSED, 16'($urandom()));
            if (p == 4) now_ms = 32'hFFFF_F000;
            case ($urandom_range(0, 4))
                0:       step_max = 0;
                1:       step_max = 3;
                2:       step_max = 40;
                3:       step_max = 200;
                default: step_max = 2000;
            endcase
            idle_on = (p < PHASES - 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) wait_all_reports();
                if (idle_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 16));
                if ($urandom_range(0, 99) == 0) now_ms += $urandom();
                else now_ms += $urandom_range(0, step_max);
                pick = $urandom_range(0, 99);
                t    = now_ms;
                if (pick < 85) begin
                    mode = MODE_SAMPLE;
                end else if (pick < 97) begin
                    mode = MODE_QUERY;
                    // sometimes ask from slightly in the past or far ahead
                    case ($urandom_range(0, 5))
                        0:       t = now_ms - $urandom_range(0, 50);
                        1:       t = now_ms + $urandom_range(0, 70000);
                        default: t = now_ms;
                    endcase
                end else begin
                    mode = MODE_UNUSED;
                end
                send_transaction(mode, random_sample(), t, 1'($urandom_range(0, 1)),
                                 CH_W'($urandom_range(0, 1)));
            end
        end
    endtask

    // a fault stops scanning; later faults and conversions are ignored
    task automatic test_fault_stop();
        logic kind;
        kind = 1'($urandom_range(0, 1));
        send_transaction(MODE_FAULT, random_sample(), now_ms, kind, 1'b0);
        send_transaction(MODE_FAULT, random_sample(), now_ms, ~kind, 1'b1);
        send_transaction(MODE_SAMPLE, random_sample(), now_ms, 1'b0, 1'b0);
        send_transaction(MODE_QUERY, random_sample(), now_ms, 1'b0, 1'b0);
        send_transaction(MODE_QUERY, random_sample(), now_ms, 1'b1, 1'b1);
    endtask

    // test sequence
    initial begin
        reset_predictor();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_query();
        test_settling();
        test_window_edges();
        test_truncation();
        test_random_traffic();
        test_fault_stop();
        wait_all_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
